// File: sv/mstt_pkg.sv
// ============================================================================
// mstt_pkg - shared types and constants for the tick timer table
// Request codes, result kinds, table sizes and the command and result words.
// ============================================================================
package mstt_pkg;

    // Table geometry and field widths
    localparam int SLOT_COUNT  = 8;
    localparam int ID_BITS     = 16;
    localparam int RELOAD_BITS = 24;
    localparam int CNT_BITS    = RELOAD_BITS + 1;
    localparam int IDX_BITS    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Request codes
    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_ADD       = 3'd1,
        REQ_ENABLE    = 3'd2,
        REQ_DISABLE   = 3'd3,
        REQ_DELETE    = 3'd4,
        REQ_QUERY_PRS = 3'd5,
        REQ_QUERY_MOD = 3'd6,
        REQ_SET_MODE  = 3'd7
    } t_req_type;

    // Result kinds
    localparam logic KIND_FIRE  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Command word
    typedef struct packed {
        t_req_type              req_type;
        logic [ID_BITS-1:0]     client_id;
        logic [RELOAD_BITS-1:0] reload_value;
        logic                   one_shot;
    } t_cmd_word;

    // Result word
    typedef struct packed {
        logic               result_kind;
        logic [ID_BITS-1:0] fired_id;
        logic               found;
        logic               mode_out;
        logic               last;
    } t_result_word;

endpackage

// File: sv/multi_slot_tick_timer_table.sv
// ============================================================================
// multi_slot_tick_timer_table - table of software timer slots
// Walks the slot table one slot per cycle through a shared increment and
// compare unit; emits fire words on ticks and one reply word per request.
// ============================================================================
// Usage:
//   Command channel: drive i_cmd and raise start; the word is taken at a
//   clock edge where start is high and busy is low. busy stays high through
//   the table walk and the closing cycle.
//   Result channel: o_result_valid marks a result word for exactly one
//   cycle; the receiver cannot stall it, so it must take every word.
//   Throughput: every command walks all SLOT_COUNT slots, one slot per
//   cycle through the single increment/compare unit, then closes in the
//   closing state; busy is high through both. busy drops in the cycle
//   that carries the final word, and the next command is taken at the end
//   of that cycle at the earliest: a command is taken only once the last
//   one is through.
//   A request reply is registered out of the closing state. Tick fires
//   come out in slot order while the walk runs, each one held back until
//   the next fire or the closing cycle so the final word carries last. A
//   tick with no fires produces no word.
//   Reset: all slots free, disabled, counters at minus one; no clearing
//   pass is needed, the block takes commands right after reset.
// ============================================================================
module multi_slot_tick_timer_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  mstt_pkg::t_cmd_word   i_cmd,
    output logic                  busy,
    output logic                  o_result_valid,
    output mstt_pkg::t_result_word o_result
);
    import mstt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // Sequencer and command state
    t_state               r_state, n_state;
    logic [IDX_BITS-1:0]  r_idx, n_idx;
    t_cmd_word            r_cmd;
    logic                 r_found, n_found;
    logic                 r_mode, n_mode;
    logic                 r_hit, n_hit;
    logic                 r_pend, n_pend;
    logic [ID_BITS-1:0]   r_pend_id, n_pend_id;

    // Slot table
    logic [ID_BITS-1:0]     r_owner  [SLOT_COUNT];
    logic                   r_en     [SLOT_COUNT];
    logic [CNT_BITS-1:0]    r_cnt    [SLOT_COUNT];
    logic [RELOAD_BITS-1:0] r_reload [SLOT_COUNT];
    logic                   r_single [SLOT_COUNT];

    // Result register
    logic                 r_out_valid, n_out_valid;
    t_result_word         r_out, n_out;

    // Current slot view and write controls
    logic [ID_BITS-1:0]   cur_owner;
    logic                 cur_en;
    logic [CNT_BITS-1:0]  cur_cnt;
    logic                 cur_single;
    logic [CNT_BITS-1:0]  cnt_inc;
    logic                 cnt_hit;
    logic                 id_match;
    logic                 accept;
    logic                 last_slot;

    logic                 wr_owner, wr_en, wr_cnt, wr_cfg, wr_single;
    logic [ID_BITS-1:0]   wr_owner_val;
    logic                 wr_en_val;
    logic [CNT_BITS-1:0]  wr_cnt_val;
    logic                 wr_single_val;

    assign accept    = start && (r_state == ST_IDLE);
    assign last_slot = (r_idx == IDX_BITS'(SLOT_COUNT - 1));

    assign cur_owner  = r_owner[r_idx];
    assign cur_en     = r_en[r_idx];
    assign cur_cnt    = r_cnt[r_idx];
    assign cur_single = r_single[r_idx];

    // Shared unit: increment and compare against the reload
    assign cnt_inc  = cur_cnt + CNT_BITS'(1);
    assign cnt_hit  = (cnt_inc == {1'b0, r_reload[r_idx]});
    assign id_match = (r_cmd.client_id != '0) && (cur_owner == r_cmd.client_id);

    // Work one slot per cycle and close the command
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_found       = r_found;
        n_mode        = r_mode;
        n_hit         = r_hit;
        n_pend        = r_pend;
        n_pend_id     = r_pend_id;
        n_out_valid   = 1'b0;
        n_out         = r_out;
        wr_owner      = 1'b0;
        wr_en         = 1'b0;
        wr_cnt        = 1'b0;
        wr_cfg        = 1'b0;
        wr_single     = 1'b0;
        wr_owner_val  = r_cmd.client_id;
        wr_en_val     = 1'b0;
        wr_cnt_val    = '1;
        wr_single_val = r_cmd.one_shot;

        unique case (r_state)
            ST_IDLE: begin
                n_idx   = '0;
                n_found = 1'b0;
                n_mode  = 1'b0;
                n_hit   = 1'b0;
                n_pend  = 1'b0;
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                unique case (r_cmd.req_type) inside
                    REQ_TICK: begin
                        if (cur_owner != '0 && cur_en) begin
                            wr_cnt = 1'b1;
                            if (cnt_hit) begin
                                // fire: restart the count, drop a one-shot slot
                                wr_cnt_val = '1;
                                if (cur_single) begin
                                    wr_en     = 1'b1;
                                    wr_en_val = 1'b0;
                                end
                                // release the held fire, hold this one
                                if (r_pend) begin
                                    n_out_valid = 1'b1;
                                    n_out = '{result_kind: KIND_FIRE, fired_id: r_pend_id,
                                              found: 1'b0, mode_out: 1'b0, last: 1'b0};
                                end
                                n_pend    = 1'b1;
                                n_pend_id = cur_owner;
                            end else begin
                                wr_cnt_val = cnt_inc;
                            end
                        end
                    end
                    REQ_ADD: begin
                        if (!r_hit && r_cmd.client_id != '0 && cur_owner == '0) begin
                            wr_owner  = 1'b1;
                            wr_en     = 1'b1;
                            wr_en_val = 1'b1;
                            wr_cnt    = 1'b1;
                            wr_cfg    = 1'b1;
                            wr_single = 1'b1;
                            n_found   = 1'b1;
                            n_hit     = 1'b1;
                        end
                    end
                    REQ_ENABLE: begin
                        if (id_match) begin
                            wr_en     = 1'b1;
                            wr_en_val = 1'b1;
                            n_found   = 1'b1;
                        end
                    end
                    REQ_SET_MODE: begin
                        if (id_match) begin
                            wr_single = 1'b1;
                            n_found   = 1'b1;
                        end
                    end
                    REQ_DISABLE, REQ_DELETE: begin
                        if (id_match && !r_hit) begin
                            wr_en        = 1'b1;
                            wr_cnt       = 1'b1;
                            wr_owner     = (r_cmd.req_type == REQ_DELETE);
                            wr_owner_val = '0;
                            n_found      = 1'b1;
                            n_hit        = 1'b1;
                        end
                    end
                    REQ_QUERY_PRS: begin
                        if (id_match) begin
                            n_found = 1'b1;
                        end
                    end
                    REQ_QUERY_MOD: begin
                        if (id_match && !r_hit) begin
                            n_found = 1'b1;
                            n_mode  = cur_single;
                            n_hit   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (last_slot) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_BITS'(1);
                end
            end
            ST_DONE: begin
                // emit the closing word
                if (r_cmd.req_type == REQ_TICK) begin
                    if (r_pend) begin
                        n_out_valid = 1'b1;
                        n_out = '{result_kind: KIND_FIRE, fired_id: r_pend_id,
                                  found: 1'b0, mode_out: 1'b0, last: 1'b1};
                    end
                end else begin
                    n_out_valid = 1'b1;
                    n_out = '{result_kind: KIND_REPLY, fired_id: r_cmd.client_id,
                              found: r_found, mode_out: r_mode, last: 1'b1};
                end
                n_pend  = 1'b0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_mode      <= 1'b0;
            r_hit       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_mode      <= n_mode;
            r_hit       <= n_hit;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the command and the result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_pend_id <= n_pend_id;
        r_out     <= n_out;
    end

    // Update the slot control fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_owner[i] <= '0;
                r_en[i]    <= 1'b0;
                r_cnt[i]   <= '1;
            end
        end else if (r_state == ST_SCAN) begin
            if (wr_owner) begin
                r_owner[r_idx] <= wr_owner_val;
            end
            if (wr_en) begin
                r_en[r_idx] <= wr_en_val;
            end
            if (wr_cnt) begin
                r_cnt[r_idx] <= wr_cnt_val;
            end
        end
    end

    // Update the slot reload and mode
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            if (wr_cfg) begin
                r_reload[r_idx] <= r_cmd.reload_value;
            end
            if (wr_single) begin
                r_single[r_idx] <= wr_single_val;
            end
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// File: sv/mstt_checker.sv
// ============================================================================
// mstt_checker - port-level checks for the tick timer table
// Watches the command and result ports and flags sequencing slips.
// ============================================================================
module mstt_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  mstt_pkg::t_cmd_word    i_cmd,
    input  logic                   busy,
    input  logic                   o_result_valid,
    input  mstt_pkg::t_result_word o_result
);
    import mstt_pkg::*;

    // A taken command makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a command was taken");

    // Results only come out of work in progress
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result word without a command in progress");

    // The final word closes the command
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last |-> !busy)
        else $error("busy still high at the final result word");

    // A word that is not final leaves the command open
    a_notlast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.last |-> busy)
        else $error("command closed without a final result word");

    // A request gets its reply after a full table walk
    a_reply_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd.req_type != REQ_TICK |->
        ##(SLOT_COUNT + 2) (o_result_valid && o_result.result_kind == KIND_REPLY))
        else $error("request reply missing or late");

endmodule

bind multi_slot_tick_timer_table mstt_checker u_mstt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .i_cmd          (i_cmd),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
